// ===== src/segment_and_page_translate_core_assert.svh =====
// Assertion macros for the segment and page translation core.
// Included by the top level; relies on nothing but the caller's clock and reset names.
`ifndef SEGMENT_AND_PAGE_TRANSLATE_CORE_ASSERT_SVH
`define SEGMENT_AND_PAGE_TRANSLATE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/spt_pkg.sv =====
// Shared types and constants for the segment and page translation core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package spt_pkg;

  localparam int unsigned NUM_SEG = 6;

  // Register indexes of the configuration port.
  localparam logic [3:0] CFG_IDX_MODE   = 4'd0;
  localparam logic [3:0] CFG_IDX_DIR    = 4'd1;
  localparam logic [3:0] CFG_IDX_SEG0   = 4'd2;
  localparam logic [3:0] CFG_IDX_SEG5   = 4'd7;

  localparam logic REQ_ACCESS   = 1'b0;
  localparam logic REQ_RESPONSE = 1'b1;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_FAULT = 2'd2;

  localparam logic [2:0] FC_NONE        = 3'd0;
  localparam logic [2:0] FC_DIR_ABSENT  = 3'd1;
  localparam logic [2:0] FC_PAGE_ABSENT = 3'd2;
  localparam logic [2:0] FC_CROSS       = 3'd3;
  localparam logic [2:0] FC_STRAY       = 3'd4;
  localparam logic [2:0] FC_BUSY        = 3'd5;

  localparam logic [12:0] PAGE_BYTES = 13'h1000;

  typedef enum logic [2:0] {
    PHASE_IDLE = 3'b001,
    PHASE_DIR  = 3'b010,
    PHASE_PAGE = 3'b100
  } phase_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] offset_addr;
    logic [2:0]  segment_select;
    logic [2:0]  access_len;
    logic [31:0] mem_word;
  } spt_in_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [31:0] out_addr;
    logic [2:0]  fault_code;
  } spt_out_t;

  typedef struct packed {
    logic [1:0]       mode_bits;
    logic [19:0]      directory_frame;
    logic [5:0][31:0] seg_base;
  } spt_cfg_t;

  typedef struct packed {
    logic walk_busy;
  } spt_status_t;

endpackage

`default_nettype wire

// ===== src/segment_and_page_translate_core.sv =====
// Segment and two-level page translation core: input register, translation step, result register.
// Depends on spt_pkg, spt_cfg_regs, spt_walk and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

// Each input transfer yields exactly one result: a table read request, a finished
// physical address or a fault. One item is taken every cycle while results drain; an
// accepted item is held in the input register and its result, from the translation logic,
// is offered from the result register. While a result waits, the item behind it stays in
// the input register and the input channel stalls until the result transfers.
// Memory words of the walk come back on the input channel as response items, so
// memory latency lies outside the block.
// Configuration writes are accepted at once and should be made while idle.
module segment_and_page_translate_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire spt_pkg::spt_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output spt_pkg::spt_out_t     out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [3:0]       cfg_index,
  input  wire logic [31:0]      cfg_data
);
  import spt_pkg::*;

  `include "segment_and_page_translate_core_assert.svh"

  logic        in_valid_r;
  spt_in_t     in_data_r;
  logic        out_valid_r;
  spt_out_t    out_data_r;
  logic        advance;
  spt_cfg_t    cfg;
  spt_out_t    result;
  spt_status_t status;
  logic        out_is_read;
  logic        out_code_ok;
  logic        busy_access;
  logic        busy_kept;
  logic        idle_response;
  logic        stray_kept;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;

  spt_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  spt_walk u_walk (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .item   (in_data_r),
    .fire   (advance),
    .result (result),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign out_is_read   = out_valid_r && out_data_r.out_kind == KIND_READ;
  assign out_code_ok   = (out_data_r.out_kind == KIND_FAULT) == (out_data_r.fault_code != FC_NONE);
  assign busy_access   = advance && status.walk_busy && in_data_r.req_type == REQ_ACCESS;
  assign busy_kept     = out_valid_r && out_data_r.fault_code == FC_BUSY && status.walk_busy;
  assign idle_response = advance && !status.walk_busy && in_data_r.req_type == REQ_RESPONSE;
  assign stray_kept    = !status.walk_busy && out_data_r.fault_code == FC_STRAY;

  // A pending read request means a walk is still waiting for its table word.
  `SPT_ASSERT_NOW(a_read_implies_walk, out_is_read, status.walk_busy, "read request while idle")
  // Fault code and result kind must agree.
  `SPT_ASSERT_NOW(a_code_matches_kind, out_valid_r, out_code_ok, "fault code and kind disagree")
  // A request that arrives during a walk is refused as busy and leaves the walk running.
  `SPT_ASSERT_NEXT(a_busy_reply, busy_access, busy_kept, "busy request not refused")
  // A stray response never starts a walk.
  `SPT_ASSERT_NEXT(a_stray_keeps_idle, idle_response, stray_kept, "stray response began a walk")

endmodule

`default_nettype wire

// ===== src/spt_cfg_regs.sv =====
// Configuration register file: mode, directory frame and six segment bases.
// Depends on spt_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module spt_cfg_regs (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire logic [3:0]      wr_index,
  input  wire logic [31:0]     wr_data,
  output spt_pkg::spt_cfg_t    cfg
);
  import spt_pkg::*;

  spt_cfg_t cfg_r;
  spt_cfg_t cfg_nxt;
  logic [3:0] seg_off;

  assign seg_off = wr_index - CFG_IDX_SEG0;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      if (wr_index == CFG_IDX_MODE) begin
        cfg_nxt.mode_bits = wr_data[1:0];
      end else if (wr_index == CFG_IDX_DIR) begin
        cfg_nxt.directory_frame = wr_data[19:0];
      end else if (wr_index >= CFG_IDX_SEG0 && wr_index <= CFG_IDX_SEG5) begin
        cfg_nxt.seg_base[seg_off[2:0]] = wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== src/spt_walk.sv =====
// Translation step and walk state: segment add, page-crossing test, two-level walk.
// Depends on spt_pkg; the result is combinational and the top level registers it.
`timescale 1ns / 1ps
`default_nettype none

module spt_walk (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire spt_pkg::spt_cfg_t   cfg,
  input  wire spt_pkg::spt_in_t    item,
  input  wire logic                fire,
  output spt_pkg::spt_out_t        result,
  output spt_pkg::spt_status_t     status
);
  import spt_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] lin_r, lin_nxt;
  logic [31:0] base;
  logic [31:0] lin;
  logic [12:0] end_byte;
  logic        crosses;
  logic        present;

  always_comb begin
    base = '0;
    if (cfg.mode_bits[0] && item.segment_select < 3'(NUM_SEG)) begin
      base = cfg.seg_base[item.segment_select];
    end
  end

  assign lin      = base + item.offset_addr;
  assign end_byte = {1'b0, lin[11:0]} + {10'd0, item.access_len};
  assign crosses  = end_byte > PAGE_BYTES;
  assign present  = item.mem_word[0];

  always_comb begin
    phase_nxt = phase_r;
    lin_nxt   = lin_r;
    result    = '{out_kind: KIND_FAULT, out_addr: '0, fault_code: FC_STRAY};
    if (item.req_type == REQ_ACCESS) begin
      if (phase_r == PHASE_DIR || phase_r == PHASE_PAGE) begin
        // The walk in flight carries on; the new request is turned away.
        result = '{out_kind: KIND_FAULT, out_addr: lin_r, fault_code: FC_BUSY};
      end else if (crosses) begin
        phase_nxt = PHASE_IDLE;
        result    = '{out_kind: KIND_FAULT, out_addr: lin, fault_code: FC_CROSS};
      end else if (cfg.mode_bits == 2'b11) begin
        lin_nxt   = lin;
        phase_nxt = PHASE_DIR;
        // The directory base is page aligned, so the add reduces to a concatenation.
        result    = '{out_kind: KIND_READ,
                      out_addr: {cfg.directory_frame, lin[31:22], 2'b00},
                      fault_code: FC_NONE};
      end else begin
        phase_nxt = PHASE_IDLE;
        result    = '{out_kind: KIND_DONE, out_addr: lin, fault_code: FC_NONE};
      end
    end else begin
      case (phase_r)
        PHASE_DIR: begin
          if (!present) begin
            phase_nxt = PHASE_IDLE;
            result = '{out_kind: KIND_FAULT, out_addr: lin_r, fault_code: FC_DIR_ABSENT};
          end else begin
            phase_nxt = PHASE_PAGE;
            result = '{out_kind: KIND_READ,
                       out_addr: {item.mem_word[31:12], lin_r[21:12], 2'b00},
                       fault_code: FC_NONE};
          end
        end
        PHASE_PAGE: begin
          phase_nxt = PHASE_IDLE;
          if (!present) begin
            result = '{out_kind: KIND_FAULT, out_addr: lin_r, fault_code: FC_PAGE_ABSENT};
          end else begin
            result = '{out_kind: KIND_DONE,
                       out_addr: {item.mem_word[31:12], lin_r[11:0]},
                       fault_code: FC_NONE};
          end
        end
        default: begin
          result = '{out_kind: KIND_FAULT, out_addr: '0, fault_code: FC_STRAY};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_IDLE;
      lin_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      lin_r   <= lin_nxt;
    end
  end

  assign status.walk_busy = (phase_r == PHASE_DIR) || (phase_r == PHASE_PAGE);

endmodule

`default_nettype wire

// ===== tb/segment_and_page_translate_core_tb.sv =====
// Self-checking testbench for the segment and two-level page translation core.
// Depends on spt_pkg and segment_and_page_translate_core; it predicts every result
// internally and compares it field by field as the result transfers complete.
`timescale 1ns / 1ps

module segment_and_page_translate_core_tb;
  import spt_pkg::*;

  localparam logic [1:0] MODE_REAL  = 2'b00;
  localparam logic [1:0] MODE_PROT  = 2'b01;
  localparam logic [1:0] MODE_PAGED = 2'b11;
  // Index with no register behind it; a write there must change nothing.
  localparam logic [3:0] CFG_IDX_UNUSED = 4'hf;
  // Worst quiet stretch of a correct run is a sender gap, a receiver stall and the
  // pipeline depth; this limit allows many times that.
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 500;

  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] value;
  } reg_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  spt_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  spt_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  spt_in_t     access_queue[$];
  reg_write_t  reg_writes[$];
  spt_out_t    awaited_results[$];

  // Predictor state and its copy of the registers.
  spt_cfg_t    model_cfg = '0;
  phase_t      walk_phase = PHASE_IDLE;
  logic [31:0] walk_linear = '0;

  int unsigned mismatches = 0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int unsigned quiet_cycles = 0;
  logic        no_idle = 1'b0;

  segment_and_page_translate_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned idle_draw();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  // Works out the result of one accepted item and advances the walk state.
  function automatic spt_out_t translate_item(spt_in_t item);
    spt_out_t    r;
    logic [31:0] lin;
    logic [31:0] frame;
    r = '{out_kind: KIND_FAULT, out_addr: '0, fault_code: FC_NONE};
    if (item.req_type == REQ_ACCESS) begin
      if (walk_phase != PHASE_IDLE) begin
        r.out_addr = walk_linear;
        r.fault_code = FC_BUSY;
      end else begin
        lin = item.offset_addr;
        if (model_cfg.mode_bits[0] && item.segment_select < NUM_SEG) begin
          lin = model_cfg.seg_base[item.segment_select] + item.offset_addr;
        end
        if (32'(lin[11:0]) + 32'(item.access_len) > 32'(PAGE_BYTES)) begin
          r.out_addr = lin;
          r.fault_code = FC_CROSS;
        end else if (model_cfg.mode_bits == MODE_PAGED) begin
          walk_linear = lin;
          walk_phase = PHASE_DIR;
          r.out_kind = KIND_READ;
          r.out_addr = {model_cfg.directory_frame, 12'b0} + {20'b0, lin[31:22], 2'b0};
        end else begin
          r.out_kind = KIND_DONE;
          r.out_addr = lin;
        end
      end
    end else begin
      frame = {item.mem_word[31:12], 12'b0};
      case (walk_phase)
        PHASE_DIR: begin
          if (!item.mem_word[0]) begin
            walk_phase = PHASE_IDLE;
            r.out_addr = walk_linear;
            r.fault_code = FC_DIR_ABSENT;
          end else begin
            walk_phase = PHASE_PAGE;
            r.out_kind = KIND_READ;
            r.out_addr = frame + {20'b0, walk_linear[21:12], 2'b0};
          end
        end
        PHASE_PAGE: begin
          walk_phase = PHASE_IDLE;
          if (!item.mem_word[0]) begin
            r.out_addr = walk_linear;
            r.fault_code = FC_PAGE_ABSENT;
          end else begin
            r.out_kind = KIND_DONE;
            r.out_addr = frame + {20'b0, walk_linear[11:0]};
          end
        end
        default: begin
          r.fault_code = FC_STRAY;
        end
      endcase
    end
    return r;
  endfunction

  // Input driver: predicts each item as its transfer completes.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(translate_item(in_data));
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (access_queue.size() != 0) begin
          in_data <= access_queue.pop_front();
          in_valid <= 1'b1;
          in_gap <= idle_draw();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Register write driver; the predictor's copy changes as each write transfers.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDX_MODE) begin
          model_cfg.mode_bits = cfg_data[1:0];
        end else if (cfg_index == CFG_IDX_DIR) begin
          model_cfg.directory_frame = cfg_data[19:0];
        end else if (cfg_index >= CFG_IDX_SEG0 && cfg_index <= CFG_IDX_SEG5) begin
          model_cfg.seg_base[cfg_index - CFG_IDX_SEG0] = cfg_data;
        end
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_writes.size() != 0) begin
          cfg_index <= reg_writes[0].index;
          cfg_data <= reg_writes[0].value;
          cfg_valid <= 1'b1;
          void'(reg_writes.pop_front());
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    spt_out_t    want;
    int unsigned n;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing awaited, got kind %0d addr %h code %0d",
                   $time, out_data.out_kind, out_data.out_addr, out_data.fault_code);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data.out_kind !== want.out_kind) begin
            $display("%0t: out_kind expected %0d, got %0d",
                     $time, want.out_kind, out_data.out_kind);
            mismatches++;
          end
          if (out_data.out_addr !== want.out_addr) begin
            $display("%0t: out_addr expected %h, got %h",
                     $time, want.out_addr, out_data.out_addr);
            mismatches++;
          end
          if (out_data.fault_code !== want.fault_code) begin
            $display("%0t: fault_code expected %0d, got %0d",
                     $time, want.fault_code, out_data.fault_code);
            mismatches++;
          end
        end
        n = idle_draw();
        out_stall <= n;
        out_ready <= (n == 0);
      end else if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready <= (out_stall == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic spt_in_t access_item(logic [31:0] off, logic [2:0] sel, logic [2:0] len);
    spt_in_t item;
    item = spt_in_t'({$urandom, $urandom, $urandom});
    item.req_type = REQ_ACCESS;
    item.offset_addr = off;
    item.segment_select = sel;
    item.access_len = len;
    return item;
  endfunction

  function automatic spt_in_t memory_item(logic [31:0] word);
    spt_in_t item;
    item = spt_in_t'({$urandom, $urandom, $urandom});
    item.req_type = REQ_RESPONSE;
    item.mem_word = word;
    return item;
  endfunction

  function automatic spt_in_t random_access();
    logic [31:0] off;
    logic [2:0]  sel;
    logic [2:0]  len;
    off = $urandom;
    // Push some offsets against the end of a page so that crossings happen.
    if ($urandom_range(0, 7) == 0) begin
      off[11:0] = 12'hfff - 12'($urandom_range(0, 6));
    end
    sel = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
    if ($urandom_range(0, 9) < 8) begin
      len = 3'(1 << $urandom_range(0, 2));
    end else begin
      len = 3'($urandom_range(0, 7));
    end
    return access_item(off, sel, len);
  endfunction

  function automatic spt_in_t random_memory(int unsigned present_pct);
    logic [31:0] word;
    word = $urandom;
    word[0] = ($urandom_range(0, 99) < present_pct);
    return memory_item(word);
  endfunction

  task automatic queue_write(logic [3:0] index, logic [31:0] value);
    reg_writes.push_back('{index: index, value: value});
  endtask

  // Upper bits of the mode write are random; only the low two matter.
  task automatic set_mode(logic [1:0] m);
    logic [31:0] v;
    v = $urandom;
    v[1:0] = m;
    queue_write(CFG_IDX_MODE, v);
  endtask

  task automatic set_directory(logic [19:0] frame);
    logic [31:0] v;
    v = $urandom;
    v[19:0] = frame;
    queue_write(CFG_IDX_DIR, v);
  endtask

  task automatic settle_writes();
    while (reg_writes.size() != 0 || cfg_valid) @(negedge clk);
  endtask

  task automatic drain();
    while (access_queue.size() != 0 || in_valid || awaited_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic logic [31:0] extreme_word();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_settings();
    logic [1:0] m;
    m = ($urandom_range(0, 9) < 7) ? MODE_PAGED : 2'($urandom_range(0, 3));
    set_mode(m);
    if ($urandom_range(0, 1) == 0) begin
      set_directory(20'(extreme_word()));
    end
    for (int i = 0; i < NUM_SEG; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        queue_write(4'(CFG_IDX_SEG0 + i), extreme_word());
      end
    end
    settle_writes();
    no_idle = ($urandom_range(0, 3) == 0);
  endtask

  // Mostly complete walks with random content; the rest is loose requests and
  // responses, and now and then a request that lands in the middle of a walk.
  task automatic random_chunk(int unsigned n, ref int unsigned made);
    int unsigned k;
    int unsigned pick;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        access_queue.push_back(random_access());
        k++;
        if ($urandom_range(0, 9) == 0) begin
          access_queue.push_back(random_access());
          k++;
        end
        access_queue.push_back(random_memory(85));
        access_queue.push_back(random_memory(85));
        k += 2;
      end else if (pick < 85) begin
        access_queue.push_back(random_access());
        k++;
      end else begin
        access_queue.push_back(random_memory(50));
        k++;
      end
    end
    made += k;
  endtask

  initial begin
    int unsigned made;
    made = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Real mode straight after reset: page boundary arithmetic and a stray response.
    access_queue.push_back(access_item(32'h0000_0000, 3'd0, 3'd1));
    access_queue.push_back(access_item(32'hffff_ffff, 3'd5, 3'd1));
    access_queue.push_back(access_item(32'h0000_0fff, 3'd2, 3'd2));
    access_queue.push_back(access_item(32'h7fff_fffc, 3'd1, 3'd4));
    access_queue.push_back(access_item(32'h0000_1234, 3'd7, 3'd0));
    access_queue.push_back(access_item(32'hffff_fff9, 3'd3, 3'd7));
    access_queue.push_back(access_item(32'h0000_0ffa, 3'd4, 3'd7));
    access_queue.push_back(memory_item(32'hffff_ffff));
    drain();

    // Protected mode: every register written, segment wrap-around and no-segment selects.
    set_mode(MODE_PROT);
    set_directory(20'hfffff);
    queue_write(CFG_IDX_SEG0, 32'h0000_0000);
    queue_write(4'(CFG_IDX_SEG0 + 1), 32'hffff_ffff);
    queue_write(4'(CFG_IDX_SEG0 + 2), 32'h1234_5000);
    queue_write(4'(CFG_IDX_SEG0 + 3), 32'h8000_0000);
    queue_write(4'(CFG_IDX_SEG0 + 4), $urandom);
    queue_write(CFG_IDX_SEG5, 32'hffff_f000);
    queue_write(CFG_IDX_UNUSED, $urandom);
    settle_writes();
    access_queue.push_back(access_item(32'h0000_0001, 3'd1, 3'd1));
    access_queue.push_back(access_item(32'h0000_0100, 3'd6, 3'd4));
    access_queue.push_back(access_item(32'h0000_1ffe, 3'd5, 3'd2));
    access_queue.push_back(access_item(32'h0000_0fff, 3'd3, 3'd4));
    drain();

    // Paging on: full walk with a busy request inside it, then each absent entry.
    set_mode(MODE_PAGED);
    settle_writes();
    access_queue.push_back(access_item(32'hffff_ffff, 3'd0, 3'd1));
    access_queue.push_back(access_item(32'h0000_0000, 3'd0, 3'd1));
    access_queue.push_back(memory_item(32'hffff_f001));
    access_queue.push_back(memory_item(32'hffff_ffff));
    access_queue.push_back(access_item(32'h0040_0000, 3'd2, 3'd2));
    access_queue.push_back(memory_item(32'hffff_fffe));
    access_queue.push_back(access_item(32'h0000_0ffc, 3'd0, 3'd4));
    access_queue.push_back(memory_item(32'h0000_0001));
    access_queue.push_back(memory_item(32'h0000_0000));
    access_queue.push_back(access_item(32'h0000_0ffd, 3'd0, 3'd4));
    access_queue.push_back(access_item(32'h0000_2abc, 3'd2, 3'd1));
    drain();

    // Paging is switched off mid-walk; the walk must still finish as it began.
    set_mode(MODE_REAL);
    settle_writes();
    access_queue.push_back(memory_item(32'h1234_5001));
    access_queue.push_back(memory_item(32'hfedc_b001));
    access_queue.push_back(memory_item(32'h0000_0001));
    drain();

    while (made < RANDOM_ITEMS) begin
      random_settings();
      random_chunk(50, made);
      drain();
    end

    no_idle = 1'b0;
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
